@@ hw/rtl/aopb_pkg.sv @@
// Shared widths, payload types and pipeline types of the alpha-over blend core.
package aopb_pkg;

    localparam int CH_W               = 8;
    localparam int PROD_W             = 2 * CH_W;
    localparam int REM_W              = 3 * CH_W;
    localparam int QUO_W              = CH_W;
    localparam int DIV_ALIGN          = QUO_W - 1;
    localparam int DSH_W              = PROD_W + DIV_ALIGN;
    localparam int NUM_COLORS         = 3;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

    localparam logic [CH_W-1:0]   CH_MAX        = {CH_W{1'b1}};

    typedef struct packed {
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_alpha;
    } t_in_pixel;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out_pixel;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic                        zero;
        logic [CH_W-1:0]             alpha;
        t_div_lane [NUM_COLORS-1:0]  lane;
    } t_div_data;

endpackage

@@ hw/rtl/aopb_if.sv @@
// Valid/ready channel interfaces for the pixel request and the blended result.
interface aopb_in_if;
    logic                 valid;
    logic                 ready;
    aopb_pkg::t_in_pixel  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aopb_out_if;
    logic                 valid;
    logic                 ready;
    aopb_pkg::t_out_pixel payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/aopb_premul.sv @@
// Two product stages that form the blend numerators, the denominator, the combined alpha and divider inputs.
module aopb_premul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  aopb_pkg::t_in_pixel i_pix,
    output logic                o_valid,
    output aopb_pkg::t_div_data o_data
);
    import aopb_pkg::*;

    logic [CH_W-1:0]   s_ch [NUM_COLORS];
    logic [CH_W-1:0]   d_ch [NUM_COLORS];

    logic              r1_valid;
    logic [PROD_W-1:0] r1_ps [NUM_COLORS];
    logic [PROD_W-1:0] r1_pd [NUM_COLORS];
    logic [PROD_W-1:0] r1_sa255;
    logic [PROD_W-1:0] r1_dinv;
    logic [CH_W-1:0]   r1_inv;

    logic [PROD_W-1:0] n1_ps [NUM_COLORS];
    logic [PROD_W-1:0] n1_pd [NUM_COLORS];
    logic [PROD_W-1:0] n1_sa255;
    logic [PROD_W-1:0] n1_dinv;
    logic [CH_W-1:0]   n1_inv;

    logic              r2_valid;
    t_div_data         r2_data;
    t_div_data         n2_data;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] alpha_sum;

    assign s_ch[0] = i_pix.src_red;
    assign s_ch[1] = i_pix.src_green;
    assign s_ch[2] = i_pix.src_blue;
    assign d_ch[0] = i_pix.dst_red;
    assign d_ch[1] = i_pix.dst_green;
    assign d_ch[2] = i_pix.dst_blue;

    always_comb begin
        n1_inv   = CH_MAX - i_pix.src_alpha;
        n1_sa255 = {i_pix.src_alpha, {CH_W{1'b0}}} - PROD_W'(i_pix.src_alpha);
        n1_dinv  = PROD_W'(i_pix.dst_alpha) * PROD_W'(n1_inv);
        for (int c = 0; c < NUM_COLORS; c++) begin
            n1_ps[c] = PROD_W'(s_ch[c]) * PROD_W'(i_pix.src_alpha);
            n1_pd[c] = PROD_W'(d_ch[c]) * PROD_W'(i_pix.dst_alpha);
        end
    end

    // The denominator never exceeds 255*255, where this sum gives its exact floor over 255.
    always_comb begin
        den           = r1_sa255 + r1_dinv;
        alpha_sum     = den + (den >> CH_W) + PROD_W'(1);
        n2_data.zero  = (den == '0);
        n2_data.alpha = alpha_sum[PROD_W-1:CH_W];
        for (int c = 0; c < NUM_COLORS; c++) begin
            n2_data.lane[c].rem = ({r1_ps[c], {CH_W{1'b0}}} - REM_W'(r1_ps[c]))
                                + REM_W'(r1_pd[c]) * REM_W'(r1_inv);
            n2_data.lane[c].dsh = {den, {DIV_ALIGN{1'b0}}};
            n2_data.lane[c].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ps    <= n1_ps;
            r1_pd    <= n1_pd;
            r1_sa255 <= n1_sa255;
            r1_dinv  <= n1_dinv;
            r1_inv   <= n1_inv;
            r2_data  <= n2_data;
        end
    end

    assign o_valid = r2_valid;
    assign o_data  = r2_data;

endmodule

@@ hw/rtl/aopb_div_stage.sv @@
// One restoring-division stage that retires two quotient bits in each of three color lanes.
module aopb_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  aopb_pkg::t_div_data i_data,
    output logic                o_valid,
    output aopb_pkg::t_div_data o_data
);
    import aopb_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    always_comb begin
        logic ge;
        n_data = i_data;
        for (int l = 0; l < NUM_COLORS; l++) begin
            for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                ge = (n_data.lane[l].rem >= REM_W'(n_data.lane[l].dsh));
                if (ge) begin
                    n_data.lane[l].rem = n_data.lane[l].rem - REM_W'(n_data.lane[l].dsh);
                end
                n_data.lane[l].quo = {n_data.lane[l].quo[QUO_W-2:0], ge};
                n_data.lane[l].dsh = n_data.lane[l].dsh >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // The partial remainder of the red and blue lanes never exceeds the divisor of the quotient bit just retired.
    a_color_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.zero) |->
        (r_data.lane[0].rem < {r_data.lane[0].dsh, 1'b1}))
        else $error("color lane remainder out of range");

    a_blue_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |->
        (r_data.lane[NUM_COLORS-1].rem < {r_data.lane[NUM_COLORS-1].dsh, 1'b1}))
        else $error("blue lane remainder out of range");

    a_zero_numerators: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.zero) |->
        (r_data.lane[0].rem == '0 && r_data.alpha == '0))
        else $error("nonzero remainder or alpha with both alphas zero");

endmodule

@@ hw/rtl/alpha_over_pixel_blend_core.sv @@
// Top level of the straight-alpha source-over-destination RGBA8888 blend core.
//
// Usage:
// A request on i_pix carries one source and one destination pixel. Each request
// produces exactly one blended pixel on o_pix, in request order. Both channels
// use valid/ready; a transfer happens on a rising edge with both high.
// The pipeline has six register stages. Two product stages come first, the second
// of which also forms the combined alpha, then four divider stages of two quotient
// bits each. Throughput is one pixel per cycle while the receiver keeps o_pix moving;
// every stage takes a new pixel in each cycle in which the pipeline is not frozen.
// The last divider stage is the output register. While o_pix is valid and the
// receiver holds ready low, the whole pipeline freezes and i_pix.ready drops, so
// nothing is lost or repeated. Bubbles inside the pipeline are kept, not squeezed.
// A synchronous active-low reset clears all valid bits; data registers are not
// cleared. When both alphas are zero the result is an all-zero pixel.
module alpha_over_pixel_blend_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aopb_in_if.sink    i_pix,
    aopb_out_if.source o_pix
);
    import aopb_pkg::*;

    logic      en;
    logic      stg_valid [DIV_STAGES+1];
    t_div_data stg_data  [DIV_STAGES+1];
    t_div_data last;

    assign en          = !stg_valid[DIV_STAGES] || o_pix.ready;
    assign i_pix.ready = en;

    aopb_premul u_premul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_pix   (i_pix.payload),
        .o_valid (stg_valid[0]),
        .o_data  (stg_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        aopb_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    assign last                     = stg_data[DIV_STAGES];
    assign o_pix.valid              = stg_valid[DIV_STAGES];
    assign o_pix.payload.out_red    = last.zero ? '0 : last.lane[0].quo;
    assign o_pix.payload.out_green  = last.zero ? '0 : last.lane[1].quo;
    assign o_pix.payload.out_blue   = last.zero ? '0 : last.lane[2].quo;
    assign o_pix.payload.out_alpha  = last.alpha;

    a_ready_only_blocked_by_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_pix.valid)
        else $error("request side stalled without a waiting result");

endmodule

@@ verif/tb_alpha_over_pixel_blend_core.sv @@
// Self-checking testbench for the straight-alpha source-over-destination blend core.
module tb_alpha_over_pixel_blend_core;
    import aopb_pkg::*;

    localparam int RAND_PIXELS   = 800;
    localparam int NUM_PHASES    = 3;
    localparam int DRAIN_CYCLES  = 12;
    localparam int STALL_LIMIT   = 5000;

    typedef struct {
        t_in_pixel  px;
        bit         known;
        t_out_pixel want;
    } t_blend_row;

    logic clk;
    logic rst_n;

    aopb_in_if  pix_in ();
    aopb_out_if pix_out ();

    alpha_over_pixel_blend_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    t_blend_row pending_q[$];
    t_out_pixel blended_q[$];
    t_blend_row cur_row;

    int send_idle_pct;
    int recv_idle_pct;
    int err_cnt;
    int req_cnt;
    int res_cnt;
    int zero_alpha_cnt;
    int stall_cycles;

    // Row layout: {sr, sg, sb, sa, dr, dg, db, da} and expected {r, g, b, a}.
    t_blend_row stim_tbl[] = '{
        '{64'h00000000_00000000, 1'b1, 32'h00000000},
        '{64'hFFFFFF00_FFFFFF00, 1'b1, 32'h00000000},
        '{64'hFF00AAFF_123456C8, 1'b1, 32'hFF00AAFF},
        '{64'h00FF55FF_FFFFFFFF, 1'b1, 32'h00FF55FF},
        '{64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{64'hFFFFFF00_0180FEFF, 1'b1, 32'h0180FEFF},
        '{64'hAB12CD00_55AA3301, 1'b1, 32'h55AA3301},
        '{64'h7F80FF01_FFFFFF00, 1'b1, 32'h7F80FF01},
        '{64'h00000000_AA5533FE, 1'b1, 32'hAA5533FE},
        '{64'hFFFFFF01_000000FF, 1'b0, 32'h0},
        '{64'h000000FE_FFFFFF01, 1'b0, 32'h0},
        '{64'hFF00FF80_00FF0080, 1'b0, 32'h0},
        '{64'hAA55AA55_55AA55AA, 1'b0, 32'h0},
        '{64'h55AA55AA_AA55AA55, 1'b0, 32'h0},
        '{64'hFFFFFF01_FFFFFF01, 1'b0, 32'h0},
        '{64'h01010101_FEFEFEFE, 1'b0, 32'h0},
        '{64'hFEFEFE7F_0101017F, 1'b0, 32'h0},
        '{64'h0F0F0F0F_F0F0F0F0, 1'b0, 32'h0}
    };

    function automatic t_out_pixel blend_over(t_in_pixel px);
        t_out_pixel   res;
        int unsigned  sa;
        int unsigned  da;
        int unsigned  den;
        int unsigned  dst_w;
        sa    = px.src_alpha;
        da    = px.dst_alpha;
        dst_w = da * (255 - sa);
        den   = sa * 255 + dst_w;
        if (den == 0) begin
            res = '0;
        end else begin
            res.out_red   = CH_W'((px.src_red   * sa * 255 + px.dst_red   * dst_w) / den);
            res.out_green = CH_W'((px.src_green * sa * 255 + px.dst_green * dst_w) / den);
            res.out_blue  = CH_W'((px.src_blue  * sa * 255 + px.dst_blue  * dst_w) / den);
            res.out_alpha = CH_W'(den / 255);
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] pick_alpha();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return '0;
        end else if (roll < 30) begin
            return CH_MAX;
        end else if (roll < 38) begin
            return CH_W'($urandom_range(1, 2));
        end else if (roll < 46) begin
            return CH_W'($urandom_range(253, 254));
        end
        return CH_W'($urandom);
    endfunction

    function automatic t_blend_row rand_row();
        t_blend_row row;
        row.px           = {$urandom, $urandom};
        row.px.src_alpha = pick_alpha();
        row.px.dst_alpha = pick_alpha();
        row.known        = 1'b0;
        row.want         = '0;
        return row;
    endfunction

    task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || pix_in.valid || blended_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        t_out_pixel want;
        if (!rst_n) begin
            pix_in.valid  <= 1'b0;
            pix_out.ready <= 1'b0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                res_cnt++;
                if (blended_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, pix_out.payload);
                end else begin
                    want = blended_q.pop_front();
                    check_field("out_red",   want.out_red,   pix_out.payload.out_red);
                    check_field("out_green", want.out_green, pix_out.payload.out_green);
                    check_field("out_blue",  want.out_blue,  pix_out.payload.out_blue);
                    check_field("out_alpha", want.out_alpha, pix_out.payload.out_alpha);
                end
            end
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);

            if (pix_in.valid && pix_in.ready) begin
                req_cnt++;
                if (cur_row.px.src_alpha == 0 && cur_row.px.dst_alpha == 0) begin
                    zero_alpha_cnt++;
                end
                blended_q.push_back(cur_row.known ? cur_row.want : blend_over(cur_row.px));
            end
            if (!pix_in.valid || pix_in.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_row = pending_q.pop_front();
                    pix_in.valid   <= 1'b1;
                    pix_in.payload <= cur_row.px;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL alpha_over_pixel_blend_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int send_pct[NUM_PHASES] = '{16, 76, 0};
        int recv_pct[NUM_PHASES] = '{76, 16, 0};
        int per_phase;
        pix_in.valid   = 1'b0;
        pix_in.payload = '0;
        pix_out.ready  = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        err_cnt        = 0;
        req_cnt        = 0;
        res_cnt        = 0;
        zero_alpha_cnt = 0;
        stall_cycles   = 0;
        per_phase      = RAND_PIXELS / NUM_PHASES;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_tbl[i]) begin
            pending_q.push_back(stim_tbl[i]);
        end
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            for (int n = 0; n < per_phase; n++) begin
                pending_q.push_back(rand_row());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (blended_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d results never arrived", $time, blended_q.size());
        end

        $display("Run covered %0d pixel requests and %0d blended results, %0d with both alphas zero.",
                 req_cnt, res_cnt, zero_alpha_cnt);
        $display("Idle mixes: receiver-heavy, sender-heavy and back-to-back; %0d errors.",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("PASS alpha_over_pixel_blend_core");
        end else begin
            $display("FAIL alpha_over_pixel_blend_core");
        end
        $finish;
    end

endmodule
